// ===== hdl/iwd_pkg.sv =====
// package with decoder codes, constants and the decode function
package iwd_pkg;

	localparam int unsigned InstrW = 32;
	localparam int unsigned IndexW = 30;

	localparam logic [23:0] Mask24 = 24'hFFFFFF;
	localparam logic [11:0] Mask12 = 12'hFFF;

	// mnemonic codes
	localparam logic [5:0] MnMrs   = 6'd16;
	localparam logic [5:0] MnMsr   = 6'd17;
	localparam logic [5:0] MnBx    = 6'd18;
	localparam logic [5:0] MnMul   = 6'd19;
	localparam logic [5:0] MnMla   = 6'd20;
	localparam logic [5:0] MnMull  = 6'd21;
	localparam logic [5:0] MnSwp   = 6'd25;
	localparam logic [5:0] MnSwpb  = 6'd26;
	localparam logic [5:0] MnLdr   = 6'd27;
	localparam logic [5:0] MnLdrh  = 6'd31;
	localparam logic [5:0] MnStrh  = 6'd32;
	localparam logic [5:0] MnLdrsb = 6'd33;
	localparam logic [5:0] MnLdrsh = 6'd34;
	localparam logic [5:0] MnLdm   = 6'd35;
	localparam logic [5:0] MnStm   = 6'd36;
	localparam logic [5:0] MnB     = 6'd37;
	localparam logic [5:0] MnSwi   = 6'd39;

	// operand form codes
	localparam logic [3:0] FmNone   = 4'd0;
	localparam logic [3:0] FmImm    = 4'd1;
	localparam logic [3:0] FmReg    = 4'd2;
	localparam logic [3:0] FmRegSi  = 4'd3;
	localparam logic [3:0] FmRegSr  = 4'd4;
	localparam logic [3:0] FmRrx    = 4'd5;
	localparam logic [3:0] FmAdImm  = 4'd6;
	localparam logic [3:0] FmAdReg  = 4'd7;
	localparam logic [3:0] FmAdScl  = 4'd8;
	localparam logic [3:0] FmAdRrx  = 4'd9;
	localparam logic [3:0] FmList   = 4'd10;
	localparam logic [3:0] FmTarget = 4'd11;
	localparam logic [3:0] FmSwiNum = 4'd12;
	localparam logic [3:0] FmRegOps = 4'd13;
	localparam logic [3:0] FmPsr    = 4'd14;

	localparam logic [1:0] ShRor = 2'd3;

	// one decoded result
	typedef struct packed {
		logic [5:0]  mnemonic;
		logic        undefined;
		logic [3:0]  cond;
		logic [3:0]  reg_hi;
		logic [3:0]  reg_mid;
		logic [3:0]  reg_shift;
		logic [3:0]  reg_lo;
		logic [3:0]  operand_form;
		logic [1:0]  shift_kind;
		logic [4:0]  shift_amount;
		logic [31:0] value;
		logic [9:0]  flag_bits;
	} dec_t;

	// rotated 8-bit immediate
	function automatic logic [31:0] rot_imm(input logic [31:0] w);
		logic [63:0] d;
		logic [4:0]  r;
		begin
			r = {w[11:8], 1'b0};
			d = {24'd0, w[7:0], 24'd0, w[7:0]} >> r;
			rot_imm = d[31:0];
		end
	endfunction

	function automatic logic [9:0] xfer_flags(input logic [31:0] w);
		xfer_flags = {6'd0, w[23], w[24], w[21], 1'b0};
	endfunction

	// full decode of one word, branch target sum done by the caller
	function automatic dec_t decode(input logic [31:0] w);
		dec_t        d;
		logic        ok;
		logic [3:0]  op;
		logic [3:0]  rn;
		logic [3:0]  rd;
		logic [3:0]  rs;
		logic [3:0]  kind;
		logic [7:0]  mid;
		begin
			d = '0;
			ok = 1'b1;
			op = w[24:21];
			rn = w[19:16];
			rd = w[15:12];
			rs = w[11:8];
			kind = w[7:4];
			mid = w[11:4];
			unique case (w[27:26])
				2'd0: begin
					if (w[25] || !w[4] || !w[7]) begin
						// data processing and status ops
						if (op[3:2] == 2'b10 && !w[20]) begin
							if (!op[0]) begin
								ok = (rn == 4'hF) && (w[11:0] == 12'd0) && !w[25];
								d.mnemonic = MnMrs;
								d.operand_form = FmPsr;
								d.flag_bits = {5'd0, w[22], 4'd0};
							end else begin
								d.flag_bits = {rn, 1'b0, w[22], 4'd0};
								if (w[25]) begin
									ok = (rd == 4'hF);
									d.mnemonic = MnMsr;
									d.operand_form = FmImm;
									d.value = rot_imm(w);
								end else if (kind == 4'd0 && rd == 4'hF && rs == 4'd0) begin
									d.mnemonic = MnMsr;
									d.operand_form = FmReg;
								end else if (op == 4'd9 && kind == 4'd1
										&& w[19:8] == Mask12) begin
									d.mnemonic = MnBx;
									d.operand_form = FmReg;
									d.flag_bits = '0;
								end else begin
									ok = 1'b0;
								end
							end
						end else begin
							if ((op == 4'd10 || op == 4'd11) && rd != 4'd0) ok = 1'b0;
							if ((op == 4'd13 || op == 4'd15) && rn != 4'd0) ok = 1'b0;
							d.mnemonic = {2'd0, op};
							d.flag_bits = {9'd0, w[20]};
							if (w[25]) begin
								d.operand_form = FmImm;
								d.value = rot_imm(w);
							end else if (mid == 8'd0) begin
								d.operand_form = FmReg;
							end else if (mid == 8'd6) begin
								d.operand_form = FmRrx;
								d.shift_kind = ShRor;
							end else begin
								d.shift_kind = w[6:5];
								if (!w[4]) begin
									d.operand_form = FmRegSi;
									d.shift_amount = w[11:7];
								end else begin
									if (w[7]) ok = 1'b0;
									d.operand_form = FmRegSr;
								end
							end
						end
					end else if (kind == 4'd9) begin
						// multiplies and swaps
						d.operand_form = FmRegOps;
						d.flag_bits = {9'd0, w[20]};
						unique case (op)
							4'd0: begin
								ok = (rd == 4'd0);
								d.mnemonic = MnMul;
							end
							4'd1: d.mnemonic = MnMla;
							4'd4, 4'd5, 4'd6, 4'd7: d.mnemonic = MnMull + {4'd0, op[1:0]};
							4'd8, 4'd10: begin
								ok = (rs == 4'd0);
								d.mnemonic = op[1] ? MnSwpb : MnSwp;
								d.flag_bits = '0;
							end
							default: ok = 1'b0;
						endcase
					end else begin
						// halfword and signed transfers
						if (kind == 4'd11) d.mnemonic = w[20] ? MnLdrh : MnStrh;
						else if (!w[20]) ok = 1'b0;
						else if (kind == 4'd13) d.mnemonic = MnLdrsb;
						else d.mnemonic = MnLdrsh;
						d.flag_bits = xfer_flags(w);
						if (w[22]) begin
							d.operand_form = FmAdImm;
							d.value = {24'd0, w[11:8], w[3:0]};
						end else begin
							if (rs != 4'd0) ok = 1'b0;
							d.operand_form = FmAdReg;
						end
						if (!w[24] && w[21]) ok = 1'b0;
					end
				end
				2'd1: begin
					// word and byte transfers
					d.mnemonic = MnLdr + {4'd0, !w[20], 1'b0} + {5'd0, w[22]};
					d.flag_bits = xfer_flags(w);
					if (!w[25]) begin
						d.operand_form = FmAdImm;
						d.value = {20'd0, w[11:0]};
					end else if (mid == 8'd0) begin
						d.operand_form = FmAdReg;
					end else if (w[4]) begin
						ok = 1'b0;
					end else begin
						d.shift_kind = w[6:5];
						d.shift_amount = w[11:7];
						if (w[6:5] == ShRor && w[11:7] == 5'd0) begin
							d.operand_form = FmAdRrx;
							d.shift_amount = 5'd0;
						end else begin
							d.operand_form = FmAdScl;
						end
					end
					if (!w[24] && w[21]) ok = 1'b0;
				end
				2'd2: begin
					if (w[25]) begin
						d.mnemonic = MnB + {5'd0, w[24]};
						d.operand_form = FmTarget;
					end else begin
						d.mnemonic = w[20] ? MnLdm : MnStm;
						d.operand_form = FmList;
						d.value = {16'd0, w[15:0]};
						d.flag_bits = xfer_flags(w) | {4'd0, w[22], 5'd0};
					end
				end
				default: begin
					ok = w[25] && w[24];
					d.mnemonic = MnSwi;
					d.operand_form = FmSwiNum;
					d.value = {8'd0, w[23:0] & Mask24};
				end
			endcase
			d.cond = w[31:28];
			d.reg_hi = rn;
			d.reg_mid = rd;
			d.reg_shift = rs;
			d.reg_lo = w[3:0];
			if (!ok) begin
				d = '0;
				d.undefined = 1'b1;
			end
			decode = d;
		end
	endfunction

endpackage

// ===== hdl/instruction_word_decoder.sv =====
// top level of the instruction word decoder
//
//  channel   signals                          handshake
//  request   start, instr_word, word_index    start & !busy
//  result    done, mnemonic .. flag_bits      done, one cycle
//
// an accepted word passes the input register, then goes through the decode
// logic into the result register.
// a new word is taken every cycle; busy is always low.
// arst_n clears the valid bits of both stages, dropping any word in flight; otherwise no request is lost or repeated.
// the receiver cannot stall, so results simply stream out.
module instruction_word_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instr_word,
	input  logic [29:0] word_index,
	output logic        done,
	output logic [5:0]  mnemonic,
	output logic        undefined,
	output logic [3:0]  cond,
	output logic [3:0]  reg_hi,
	output logic [3:0]  reg_mid,
	output logic [3:0]  reg_shift,
	output logic [3:0]  reg_lo,
	output logic [3:0]  operand_form,
	output logic [1:0]  shift_kind,
	output logic [4:0]  shift_amount,
	output logic [31:0] value,
	output logic [9:0]  flag_bits
);

	logic        vld_s1;
	logic [31:0] word_s1;
	logic [29:0] idx_s1;
	logic        vld_s2;
	iwd_pkg::dec_t res_s2;
	iwd_pkg::dec_t dec;
	logic [31:0] target;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_s1 <= instr_word;
			idx_s1 <= word_index;
		end
	end

	// decode and branch target
	assign target = {idx_s1, 2'b00} + 32'd8 + {{6{word_s1[23]}}, word_s1[23:0], 2'b00};

	always_comb begin
		dec = iwd_pkg::decode(word_s1);
		if (!dec.undefined && dec.operand_form == iwd_pkg::FmTarget) dec.value = target;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= dec;
		end
	end

	assign done = vld_s2;
	assign mnemonic = res_s2.mnemonic;
	assign undefined = res_s2.undefined;
	assign cond = res_s2.cond;
	assign reg_hi = res_s2.reg_hi;
	assign reg_mid = res_s2.reg_mid;
	assign reg_shift = res_s2.reg_shift;
	assign reg_lo = res_s2.reg_lo;
	assign operand_form = res_s2.operand_form;
	assign shift_kind = res_s2.shift_kind;
	assign shift_amount = res_s2.shift_amount;
	assign value = res_s2.value;
	assign flag_bits = res_s2.flag_bits;

endmodule

// ===== hdl/iwd_checker.sv =====
// port-level checker for the instruction word decoder, with its bind
module iwd_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [5:0]  mnemonic,
	input logic        undefined,
	input logic [3:0]  operand_form,
	input logic [31:0] value
);

	// every accepted request yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done) else $error("missing result");

	// no result without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2)) else $error("spurious result");

	// an undefined word shows nothing else
	a_undef_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && undefined |-> mnemonic == 6'd0 && value == 32'd0 && operand_form == 4'd0)
		else $error("undefined result not cleared");

	// mnemonic stays within its code range
	a_mn_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> mnemonic <= 6'd39) else $error("mnemonic out of range");

endmodule

bind instruction_word_decoder iwd_port_props u_iwd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.mnemonic(mnemonic), .undefined(undefined), .operand_form(operand_form),
	.value(value)
);

// ===== dv/iwd_checker.sv =====
// checker module: predicts decoded words and compares them with the results
module iwd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] instr_word,
	input  logic [29:0] word_index,
	input  logic        done,
	input  logic [5:0]  mnemonic,
	input  logic        undefined,
	input  logic [3:0]  cond,
	input  logic [3:0]  reg_hi,
	input  logic [3:0]  reg_mid,
	input  logic [3:0]  reg_shift,
	input  logic [3:0]  reg_lo,
	input  logic [3:0]  operand_form,
	input  logic [1:0]  shift_kind,
	input  logic [4:0]  shift_amount,
	input  logic [31:0] value,
	input  logic [9:0]  flag_bits,
	output int          fail_count,
	output int          pending
);

	iwd_pkg::dec_t decoded_q[$];

	// rotate an 8-bit immediate right by twice the rotate nibble
	function automatic logic [31:0] rotated_imm(input logic [31:0] w);
		logic [31:0] v;
		int r;
		v = {24'd0, w[7:0]};
		r = int'(w[11:8]) * 2;
		if (r == 0) return v;
		return (v >> r) | (v << (32 - r));
	endfunction

	// address mode flags: writeback, pre-index, up
	function automatic logic [9:0] addr_flags(input logic [31:0] w);
		return {6'd0, w[23], w[24], w[21], 1'b0};
	endfunction

	// predicted decode of one word
	function automatic iwd_pkg::dec_t predict_decode(input logic [31:0] w,
			input logic [29:0] idx);
		iwd_pkg::dec_t d;
		logic ok;
		logic [3:0] op;
		logic [31:0] off;
		d = '0;
		ok = 1'b1;
		op = w[24:21];
		case (w[27:26])
			2'd0: begin
				if (w[25] || !w[4] || !w[7]) begin
					if (op >= 4'd8 && op <= 4'd11 && !w[20]) begin
						if (op == 4'd8 || op == 4'd10) begin
							ok = w[19:16] == 4'hF && w[11:0] == 12'd0 && !w[25];
							d.mnemonic = iwd_pkg::MnMrs; d.operand_form = iwd_pkg::FmPsr;
							d.flag_bits = 10'(w[22]) << 4;
						end else begin
							d.flag_bits = (10'(w[22]) << 4) | (10'(w[19:16]) << 6);
							if (w[25]) begin
								ok = w[15:12] == 4'hF;
								d.mnemonic = iwd_pkg::MnMsr; d.operand_form = iwd_pkg::FmImm;
								d.value = rotated_imm(w);
							end else if (w[7:4] == 4'd0 && w[15:12] == 4'hF
									&& w[11:8] == 4'd0) begin
								d.mnemonic = iwd_pkg::MnMsr; d.operand_form = iwd_pkg::FmReg;
							end else if (op == 4'd9 && w[7:4] == 4'd1
									&& w[19:8] == 12'hFFF) begin
								d.mnemonic = iwd_pkg::MnBx; d.operand_form = iwd_pkg::FmReg;
								d.flag_bits = '0;
							end else ok = 1'b0;
						end
					end else begin
						if ((op == 4'd10 || op == 4'd11) && w[15:12] != 4'd0) ok = 1'b0;
						if ((op == 4'd13 || op == 4'd15) && w[19:16] != 4'd0) ok = 1'b0;
						d.mnemonic = 6'(op);
						d.flag_bits = 10'(w[20]);
						if (w[25]) begin
							d.operand_form = iwd_pkg::FmImm; d.value = rotated_imm(w);
						end else if (w[11:4] == 8'd0) d.operand_form = iwd_pkg::FmReg;
						else if (w[11:4] == 8'd6) begin
							d.operand_form = iwd_pkg::FmRrx; d.shift_kind = iwd_pkg::ShRor;
						end else begin
							d.shift_kind = w[6:5];
							if (!w[4]) begin
								d.operand_form = iwd_pkg::FmRegSi; d.shift_amount = w[11:7];
							end else begin
								if (w[7]) ok = 1'b0;
								d.operand_form = iwd_pkg::FmRegSr;
							end
						end
					end
				end else if (w[7:4] == 4'd9) begin
					d.operand_form = iwd_pkg::FmRegOps;
					d.flag_bits = 10'(w[20]);
					if (op == 4'd0) begin
						ok = w[15:12] == 4'd0; d.mnemonic = iwd_pkg::MnMul;
					end else if (op == 4'd1) d.mnemonic = iwd_pkg::MnMla;
					else if (op >= 4'd4 && op <= 4'd7)
						d.mnemonic = iwd_pkg::MnMull + 6'(op - 4'd4);
					else if (op == 4'd8 || op == 4'd10) begin
						ok = w[11:8] == 4'd0;
						d.mnemonic = (op == 4'd8) ? iwd_pkg::MnSwp : iwd_pkg::MnSwpb;
						d.flag_bits = '0;
					end else ok = 1'b0;
				end else begin
					if (w[7:4] == 4'd11) d.mnemonic = w[20] ? iwd_pkg::MnLdrh : iwd_pkg::MnStrh;
					else if (!w[20]) ok = 1'b0;
					else if (w[7:4] == 4'd13) d.mnemonic = iwd_pkg::MnLdrsb;
					else d.mnemonic = iwd_pkg::MnLdrsh;
					d.flag_bits = addr_flags(w);
					if (w[22]) begin
						d.operand_form = iwd_pkg::FmAdImm; d.value = {24'd0, w[11:8], w[3:0]};
					end else begin
						if (w[11:8] != 4'd0) ok = 1'b0;
						d.operand_form = iwd_pkg::FmAdReg;
					end
					if (!w[24] && w[21]) ok = 1'b0;
				end
			end
			2'd1: begin
				d.mnemonic = iwd_pkg::MnLdr + (w[20] ? 6'd0 : 6'd2) + 6'(w[22]);
				d.flag_bits = addr_flags(w);
				if (!w[25]) begin
					d.operand_form = iwd_pkg::FmAdImm; d.value = {20'd0, w[11:0]};
				end else if (w[11:4] == 8'd0) d.operand_form = iwd_pkg::FmAdReg;
				else if (w[4]) ok = 1'b0;
				else if (w[6:5] == 2'd3 && w[11:7] == 5'd0) begin
					d.operand_form = iwd_pkg::FmAdRrx; d.shift_kind = iwd_pkg::ShRor;
				end else begin
					d.operand_form = iwd_pkg::FmAdScl;
					d.shift_kind = w[6:5]; d.shift_amount = w[11:7];
				end
				if (!w[24] && w[21]) ok = 1'b0;
			end
			2'd2: begin
				if (w[25]) begin
					off = {{8{w[23]}}, w[23:0]};
					d.mnemonic = iwd_pkg::MnB + 6'(w[24]);
					d.operand_form = iwd_pkg::FmTarget;
					d.value = {idx, 2'b00} + 32'd8 + (off << 2);
				end else begin
					d.mnemonic = w[20] ? iwd_pkg::MnLdm : iwd_pkg::MnStm;
					d.operand_form = iwd_pkg::FmList;
					d.value = {16'd0, w[15:0]};
					d.flag_bits = addr_flags(w) | (10'(w[22]) << 5);
				end
			end
			default: begin
				ok = w[25] && w[24];
				d.mnemonic = iwd_pkg::MnSwi; d.operand_form = iwd_pkg::FmSwiNum;
				d.value = {8'd0, w[23:0]};
			end
		endcase
		d.cond = w[31:28];
		d.reg_hi = w[19:16];
		d.reg_mid = w[15:12];
		d.reg_shift = w[11:8];
		d.reg_lo = w[3:0];
		if (!ok) begin
			d = '0;
			d.undefined = 1'b1;
		end
		return d;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	assign pending = decoded_q.size();

	// record requests and compare results at each edge
	always @(posedge clk or negedge arst_n) begin
		iwd_pkg::dec_t e;
		if (!arst_n) begin
			fail_count = 0;
			decoded_q.delete();
		end else begin
			if (done) begin
				if (decoded_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					e = decoded_q.pop_front();
					check_field("mnemonic", 32'(e.mnemonic), 32'(mnemonic));
					check_field("undefined", 32'(e.undefined), 32'(undefined));
					check_field("cond", 32'(e.cond), 32'(cond));
					check_field("reg_hi", 32'(e.reg_hi), 32'(reg_hi));
					check_field("reg_mid", 32'(e.reg_mid), 32'(reg_mid));
					check_field("reg_shift", 32'(e.reg_shift), 32'(reg_shift));
					check_field("reg_lo", 32'(e.reg_lo), 32'(reg_lo));
					check_field("operand_form", 32'(e.operand_form), 32'(operand_form));
					check_field("shift_kind", 32'(e.shift_kind), 32'(shift_kind));
					check_field("shift_amount", 32'(e.shift_amount), 32'(shift_amount));
					check_field("value", e.value, value);
					check_field("flag_bits", 32'(e.flag_bits), 32'(flag_bits));
				end
			end
			if (start && !busy)
				decoded_q.push_back(predict_decode(instr_word, word_index));
		end
	end
endmodule

// ===== dv/instruction_word_decoder_tb.sv =====
// testbench top: drives instruction words and gives the verdict
module instruction_word_decoder_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] instr_word = '0;
	logic [29:0] word_index = '0;
	logic        done;
	logic [5:0]  mnemonic;
	logic        undefined;
	logic [3:0]  cond, reg_hi, reg_mid, reg_shift, reg_lo, operand_form;
	logic [1:0]  shift_kind;
	logic [4:0]  shift_amount;
	logic [31:0] value;
	logic [9:0]  flag_bits;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;

	localparam int IdleLimit = 2000;

	always #5 clk = ~clk;

	instruction_word_decoder dut (.*);
	iwd_checker chk (.*);

	// watchdog on cycles without an accepted request or result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("instruction_word_decoder verification failed");
			$finish;
		end
	end

	// one request, held until accepted, then a random gap when gaps is set
	task automatic send_word(input logic [31:0] w, input logic [29:0] idx, input bit gaps);
		int gap;
		start <= 1'b1;
		instr_word <= w;
		word_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		gap = gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random word biased toward the well-formed parts of each class
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 11))
			0: w[27:26] = 2'd0;
			1: begin w[27:25] = 3'd0; w[7:4] = 4'd9; end
			2: begin
				w[27:25] = 3'd0; w[7] = 1'b1; w[4] = 1'b1;
				w[22] = 1'($urandom_range(0, 1));
			end
			3: begin w[27:26] = 2'd0; w[24:23] = 2'b10; w[20] = 1'b0; w[15:12] = 4'hF; end
			4: begin w[27:20] = 8'h12; w[19:8] = 12'hFFF; w[7:4] = 4'd1; end
			5: begin w[27:23] = 5'b00010; w[21:16] = 6'h0F; w[11:0] = 12'd0; end
			6, 7: w[27:26] = 2'd1;
			8: w[27:26] = 2'd2;
			9: w[27:26] = 2'd3;
			10: if ($urandom_range(0, 1)) w[24] = 1'b1; else w[21] = 1'b0;
			default: begin w[27:26] = 2'd0; w[11:4] = 8'd0; w[15:12] = 4'd0; w[19:16] = 4'd0; end
		endcase
		return w;
	endfunction

	logic [31:0] directed[$] = '{
		32'h00000000, 32'hFFFFFFFF, 32'hE1A00000, 32'hE3A004FF, 32'hE1A00062,
		32'hE0810312, 32'hE0810392, 32'hE1500000, 32'hE1501000, 32'hE1300000,
		32'hE10F0000, 32'hE14F0000, 32'hE329F0FF, 32'hE129F001, 32'hE12FFF11,
		32'hE0000291, 32'hE0200291, 32'hE0810392 ^ 32'h00000100, 32'hE0C10392,
		32'hE1012092, 32'hE1412092, 32'hE1D010B2, 32'hE09010B2, 32'hE02010B2,
		32'hE7900001, 32'hE7900061, 32'hE7900011, 32'hE6300000, 32'hE8BD8000,
		32'hEAFFFFFF, 32'hEB800000, 32'hEF123456, 32'hEE000000, 32'hE01010D2,
		32'hE01010F2
	};

	initial begin
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed words, both extremes of the index
		foreach (directed[i])
			send_word(directed[i], (i % 2) ? 30'h3FFFFFFF : 30'd0, i > 20);
		// random words, with stretches without gaps
		for (n = 0; n < 1350; n++)
			send_word(random_word(), 30'($urandom), (n / 100) % 3 != 1);
		start <= 1'b0;
		n = 0;
		while (pending != 0 && n < 1000) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("instruction_word_decoder verification clean");
		else
			$display("instruction_word_decoder verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/iwd_pkg.sv
hdl/instruction_word_decoder.sv
hdl/iwd_checker.sv
dv/iwd_checker.sv
dv/instruction_word_decoder_tb.sv
